/* hdl/block_list_substring_mover_assert.svh */
// assertion macros used by the checker of the block list substring mover
`ifndef BLOCK_LIST_SUBSTRING_MOVER_ASSERT_SVH
`define BLOCK_LIST_SUBSTRING_MOVER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define BLSM_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define BLSM_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) else $error(msg);

`endif

/* hdl/blsm_pkg.sv */
// shared constants and types of the block list substring mover
package blsm_pkg;

	localparam int MAX_LEN_DEF    = 4096;
	localparam int MAX_BLOCKS_DEF = 64;

	localparam int       THR_W     = 7;
	localparam logic [6:0] THR_RESET = 7'd64;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_CUT    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// control of the character store
	typedef struct packed {
		logic wr_en;   // append write into the live bank
		logic cp_en;   // flatten copy write into the spare bank
		logic swap;    // spare bank becomes the live bank
	} chr_ctl_t;

endpackage

/* hdl/blsm_chars.sv */
// two-bank character store, live bank plus flatten target
module blsm_chars #(
	parameter int MAX_LEN = blsm_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  blsm_pkg::chr_ctl_t         ctl,
	input  logic [$clog2(MAX_LEN)-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic [$clog2(MAX_LEN)-1:0] cp_addr,
	input  logic [$clog2(MAX_LEN)-1:0] rd_addr,
	output logic [7:0]                 rd_data
);

	localparam int ADDR_W = $clog2(MAX_LEN);

	logic [7:0] mem0 [MAX_LEN];
	logic [7:0] mem1 [MAX_LEN];
	logic       bank_q;
	logic       rbank_q;
	logic [7:0] rd0_q;
	logic [7:0] rd1_q;
	logic       we0;
	logic       we1;
	logic [ADDR_W-1:0] wa;
	logic [7:0]        wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
		end else if (ctl.swap) begin
			bank_q <= ~bank_q;
		end
	end

	// copy writes go to the spare bank, appends to the live one
	assign we0 = (ctl.wr_en && !bank_q) || (ctl.cp_en && bank_q);
	assign we1 = (ctl.wr_en && bank_q) || (ctl.cp_en && !bank_q);
	assign wa  = ctl.cp_en ? cp_addr : wr_addr;
	assign wd  = ctl.cp_en ? rd_data : wr_data;

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wa] <= wd;
		end
		rd0_q <= mem0[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[wa] <= wd;
		end
		rd1_q <= mem1[rd_addr];
	end

	always_ff @(posedge clk) begin
		rbank_q <= bank_q;
	end

	assign rd_data = rbank_q ? rd1_q : rd0_q;

endmodule

/* hdl/block_list_substring_mover.sv */
// block list substring mover: sequencer, block and split tables, character store
// one word at a time; in_ready is high only while idle, the result register frees the input
// append reads the last block entry, then extends that block or opens a new one; read walks the blocks in order
// cut splits each block into pieces, then moves them in two passes; flatten copies block by block, char by char
// all of it runs on one sequencer over table memories with one write and one read port and registered reads
// arst_n clears control only; tables and store are undefined until written, no clearing pass
module block_list_substring_mover #(
	parameter int MAX_LEN    = blsm_pkg::MAX_LEN_DEF,
	parameter int MAX_BLOCKS = blsm_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        first,
	input  logic [7:0]  char_in,
	input  logic [12:0] pos_a,
	input  logic [12:0] pos_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_out,
	output logic        status,
	output logic [7:0]  block_count
);

	localparam int TBL    = 2 * MAX_BLOCKS + 4;
	localparam int IDX_W  = $clog2(TBL);
	localparam int CNT_W  = $clog2(TBL + 1);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int POS_W  = (LEN_W + IDX_W > 14) ? LEN_W + IDX_W : 14;

	typedef struct packed {
		logic [LEN_W-1:0] lo;
		logic [LEN_W-1:0] hi;
	} span_t;

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_APP_RD = 18'h00002,
		S_APP_WR = 18'h00004,
		S_THR    = 18'h00008,
		S_F_BRD  = 18'h00010,
		S_F_BUSE = 18'h00020,
		S_F_CRD  = 18'h00040,
		S_F_CWR  = 18'h00080,
		S_F_END  = 18'h00100,
		S_C_RD   = 18'h00200,
		S_C_SPL  = 18'h00400,
		S_C_WR   = 18'h00800,
		S_M_RD   = 18'h01000,
		S_M_WR   = 18'h02000,
		S_R_RD   = 18'h04000,
		S_R_CHK  = 18'h08000,
		S_R_CH   = 18'h10000,
		S_DONE   = 18'h20000
	} state_t;

	// reversed spans count as empty
	function automatic logic [LEN_W-1:0] span_len(input span_t s);
		span_len = (s.hi >= s.lo) ? s.hi - s.lo : '0;
	endfunction

	state_t             state_q;
	logic [1:0]         cmd_q;
	logic               first_q;
	logic [7:0]         ch_q;
	logic [POS_W-1:0]   a_q;
	logic [POS_W-1:0]   b_q;
	logic [6:0]         thr_q;
	logic [CNT_W-1:0]   num_q;
	logic [LEN_W-1:0]   len_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   nxt_pos_q;
	logic               pass_q;
	logic [LEN_W-1:0]   j_q;
	logic [LEN_W-1:0]   jhi_q;
	logic [LEN_W-1:0]   k_q;
	logic [LEN_W-1:0]   bd0_q;
	logic [LEN_W-1:0]   bd1_q;
	logic [LEN_W-1:0]   bd2_q;
	logic [LEN_W-1:0]   bd3_q;
	logic [1:0]         np_q;
	logic [7:0]         res_q;
	logic               stat_q;
	logic               out_valid_q;
	logic [7:0]         char_out_q;
	logic               status_q;
	logic [7:0]         bc_q;

	// block table and split table, one write and one read port each, registered read
	span_t              bt_mem [TBL];
	span_t              st_mem [TBL];
	span_t              bt_rd_q;
	span_t              st_rd_q;
	logic [IDX_W-1:0]   bt_ra;
	logic               bt_we;
	logic [IDX_W-1:0]   bt_wa;
	span_t              bt_wd;
	logic               st_we;
	span_t              st_wd;

	blsm_pkg::chr_ctl_t chr_ctl;
	logic [ADDR_W-1:0]  chr_wa;
	logic [ADDR_W-1:0]  chr_ra;
	logic [7:0]         chr_rd;

	logic [CNT_W-1:0]   num_m1;
	logic [LEN_W-1:0]   sp_len;
	logic [POS_W-1:0]   end_pos;
	logic               has_a;
	logic               has_b;
	logic [LEN_W-1:0]   ca;
	logic [LEN_W-1:0]   cb;
	logic               app_full;
	logic               str_empty;
	logic               app_grow;
	logic               in_rng;
	logic               to_flat;
	logic [15:0]        thr_eff;

	assign num_m1    = num_q - CNT_W'(1);
	assign app_full  = (len_q == LEN_W'(MAX_LEN));
	// an empty string is the single empty block left by reset, its entry never written
	assign str_empty = (len_q == '0);
	assign app_grow  = first_q || str_empty || (bt_rd_q.hi == len_q);

	// split geometry of the block just read, relative to the running position
	assign sp_len  = span_len(bt_rd_q);
	assign end_pos = pos_q + POS_W'(sp_len);
	assign has_a   = (pos_q < a_q) && (end_pos > a_q);
	assign has_b   = (pos_q < b_q) && (end_pos > b_q);
	assign ca      = LEN_W'(POS_W'(bt_rd_q.lo) + a_q - pos_q);
	assign cb      = LEN_W'(POS_W'(bt_rd_q.lo) + b_q - pos_q);

	// piece lies in the moved range when its start does
	assign in_rng  = (pos_q >= a_q) && (pos_q < b_q);

	// threshold capped at the table budget
	assign thr_eff = (16'(thr_q) < 16'(MAX_BLOCKS)) ? 16'(thr_q) : 16'(MAX_BLOCKS);
	assign to_flat = 16'(num_q) > thr_eff;

	always_ff @(posedge clk) begin
		if (bt_we) begin
			bt_mem[bt_wa] <= bt_wd;
		end
		bt_rd_q <= bt_mem[bt_ra];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[cnt_q[IDX_W-1:0]] <= st_wd;
		end
		st_rd_q <= st_mem[i_q[IDX_W-1:0]];
	end

	// table and store access per sequencer step
	always_comb begin
		bt_ra         = i_q[IDX_W-1:0];
		bt_we         = 1'b0;
		bt_wa         = num_q[IDX_W-1:0];
		bt_wd         = st_rd_q;
		st_we         = 1'b0;
		st_wd.lo      = bd0_q;
		st_wd.hi      = bd1_q;
		chr_ctl.wr_en = 1'b0;
		chr_ctl.cp_en = 1'b0;
		chr_ctl.swap  = 1'b0;
		chr_wa        = len_q[ADDR_W-1:0];
		chr_ra        = j_q[ADDR_W-1:0];
		case (state_q)
			S_APP_RD: begin
				bt_ra         = num_m1[IDX_W-1:0];
				chr_ctl.wr_en = !app_full;
			end
			S_APP_WR: begin
				bt_we = 1'b1;
				if (app_grow) begin
					bt_wa    = num_m1[IDX_W-1:0];
					bt_wd.lo = (first_q || str_empty) ? '0 : bt_rd_q.lo;
				end else begin
					bt_wd.lo = len_q;
				end
				bt_wd.hi = len_q + LEN_W'(1);
			end
			S_F_CWR: begin
				chr_ctl.cp_en = 1'b1;
			end
			S_F_END: begin
				chr_ctl.swap = 1'b1;
				bt_we        = 1'b1;
				bt_wa        = '0;
				bt_wd.lo     = '0;
				bt_wd.hi     = len_q;
			end
			S_C_WR: begin
				st_we = 1'b1;
			end
			S_M_WR: begin
				bt_we = (in_rng == pass_q);
			end
			S_R_CHK: begin
				chr_ra = ca[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	blsm_chars #(
		.MAX_LEN (MAX_LEN)
	) u_chars (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (chr_ctl),
		.wr_addr (chr_wa),
		.wr_data (ch_q),
		.cp_addr (k_q[ADDR_W-1:0]),
		.rd_addr (chr_ra),
		.rd_data (chr_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= blsm_pkg::CMD_APPEND;
			first_q     <= 1'b0;
			ch_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			thr_q       <= blsm_pkg::THR_RESET;
			num_q       <= CNT_W'(1);
			len_q       <= '0;
			i_q         <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			nxt_pos_q   <= '0;
			pass_q      <= 1'b0;
			j_q         <= '0;
			jhi_q       <= '0;
			k_q         <= '0;
			bd0_q       <= '0;
			bd1_q       <= '0;
			bd2_q       <= '0;
			bd3_q       <= '0;
			np_q        <= '0;
			res_q       <= '0;
			stat_q      <= 1'b0;
			out_valid_q <= 1'b0;
			char_out_q  <= '0;
			status_q    <= 1'b0;
			bc_q        <= '0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			// the done state reloads the result register itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						first_q <= first;
						ch_q    <= char_in;
						a_q     <= POS_W'(pos_a);
						b_q     <= POS_W'(pos_b);
						i_q     <= '0;
						pos_q   <= '0;
						cnt_q   <= '0;
						res_q   <= '0;
						stat_q  <= 1'b0;
						case (cmd)
							blsm_pkg::CMD_APPEND: begin
								if (first) begin
									len_q <= '0;
									num_q <= CNT_W'(1);
								end
								state_q <= S_APP_RD;
							end
							blsm_pkg::CMD_CUT: begin
								// cutting the empty string leaves its one empty block
								state_q <= str_empty ? S_THR : S_C_RD;
							end
							blsm_pkg::CMD_READ: begin
								if (POS_W'(pos_a) >= POS_W'(len_q)) begin
									stat_q  <= 1'b1;
									state_q <= S_DONE;
								end else begin
									state_q <= S_R_RD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_APP_RD: begin
					if (app_full) begin
						stat_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_APP_WR;
					end
				end
				S_APP_WR: begin
					if (!app_grow) begin
						num_q <= num_q + CNT_W'(1);
					end
					len_q   <= len_q + LEN_W'(1);
					state_q <= S_THR;
				end
				S_THR: begin
					if (to_flat) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= S_F_BRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				// flatten: copy blocks in order into the spare bank
				S_F_BRD: begin
					state_q <= (i_q == num_q) ? S_F_END : S_F_BUSE;
				end
				S_F_BUSE: begin
					j_q     <= bt_rd_q.lo;
					jhi_q   <= bt_rd_q.hi;
					state_q <= S_F_CRD;
				end
				S_F_CRD: begin
					if (j_q < jhi_q) begin
						if (k_q < LEN_W'(MAX_LEN)) begin
							state_q <= S_F_CWR;
						end else begin
							j_q <= jhi_q;
						end
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_F_BRD;
					end
				end
				S_F_CWR: begin
					k_q     <= k_q + LEN_W'(1);
					j_q     <= j_q + LEN_W'(1);
					state_q <= S_F_CRD;
				end
				S_F_END: begin
					num_q   <= CNT_W'(1);
					state_q <= S_DONE;
				end
				// cut, first pass: split blocks at a and b into the split table
				S_C_RD: begin
					if (i_q == num_q) begin
						pass_q  <= 1'b0;
						i_q     <= '0;
						pos_q   <= '0;
						num_q   <= '0;
						state_q <= S_M_RD;
					end else begin
						state_q <= S_C_SPL;
					end
				end
				S_C_SPL: begin
					bd0_q     <= bt_rd_q.lo;
					nxt_pos_q <= end_pos;
					if (has_a && has_b) begin
						bd1_q <= ca;
						bd2_q <= cb;
						bd3_q <= bt_rd_q.hi;
						np_q  <= 2'd3;
					end else if (has_a || has_b) begin
						bd1_q <= has_a ? ca : cb;
						bd2_q <= bt_rd_q.hi;
						np_q  <= 2'd2;
					end else begin
						bd1_q <= bt_rd_q.hi;
						np_q  <= 2'd1;
					end
					state_q <= S_C_WR;
				end
				S_C_WR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					bd0_q <= bd1_q;
					bd1_q <= bd2_q;
					bd2_q <= bd3_q;
					np_q  <= np_q - 2'd1;
					if (np_q == 2'd1) begin
						pos_q   <= nxt_pos_q;
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_C_RD;
					end
				end
				// cut, move passes: pieces outside the range, then those inside
				S_M_RD: begin
					if (i_q == cnt_q) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							i_q    <= '0;
							pos_q  <= '0;
						end else begin
							state_q <= S_THR;
						end
					end else begin
						state_q <= S_M_WR;
					end
				end
				S_M_WR: begin
					if (in_rng == pass_q) begin
						num_q <= num_q + CNT_W'(1);
					end
					pos_q   <= pos_q + POS_W'(span_len(st_rd_q));
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_M_RD;
				end
				// read: walk blocks to the one holding the position
				S_R_RD: begin
					state_q <= (i_q == num_q) ? S_DONE : S_R_CHK;
				end
				S_R_CHK: begin
					if (a_q < end_pos) begin
						state_q <= S_R_CH;
					end else begin
						pos_q   <= end_pos;
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_R_RD;
					end
				end
				S_R_CH: begin
					res_q   <= chr_rd;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						char_out_q  <= res_q;
						status_q    <= stat_q;
						bc_q        <= 8'(num_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign char_out    = char_out_q;
	assign status      = status_q;
	assign block_count = bc_q;

endmodule

/* hdl/blsm_checker.sv */
// port-level checker of the block list substring mover, bound to the top level
`include "block_list_substring_mover_assert.svh"

module blsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [6:0]  cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic        first,
	input logic [7:0]  char_in,
	input logic [12:0] pos_a,
	input logic [12:0] pos_b,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  char_out,
	input logic        status,
	input logic [7:0]  block_count
);

	// a stalled result word holds
	`BLSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_out) && $stable(status) && $stable(block_count), "result word changed while stalled")

	// a nonzero character only comes from a good read
	`BLSM_ASSERT_IMP(a_char_ok, out_valid && (char_out != 8'd0), status == 1'b0, "character returned with error status")

	// the sequencer is busy right after taking a word
	`BLSM_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "input taken again without processing")

endmodule

bind block_list_substring_mover blsm_checker u_blsm_checker (.*);

/* tb/testbench.sv */
// self-checking testbench of the block list substring mover, scoreboard class plus driver tasks
module testbench;

	localparam int          STORE_LEN  = blsm_pkg::MAX_LEN_DEF;
	localparam int unsigned BLOCKS     = blsm_pkg::MAX_BLOCKS_DEF;
	localparam int          TBL        = 2 * blsm_pkg::MAX_BLOCKS_DEF + 4;  // table entries
	localparam int          CYCLE_CAP  = 4_000_000;    // generous bound on the whole run
	localparam logic [1:0]  CMD_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic        first;
	logic [7:0]  char_in;
	logic [12:0] pos_a;
	logic [12:0] pos_b;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  char_out;
	logic        status;
	logic [7:0]  block_count;

	typedef struct {
		logic [7:0] chr;
		logic       st;
		logic [7:0] blocks;
	} mover_result_t;

	// mirror of the block list: blocks, character store, threshold, pending results
	class blsm_scoreboard;
		int unsigned   blk_lo[TBL], blk_hi[TBL];
		int unsigned   piece_lo[TBL], piece_hi[TBL];
		logic [7:0]    chars[STORE_LEN];
		int unsigned   nblk;
		int unsigned   slen;
		int unsigned   thr;
		mover_result_t pending[$];
		int            errors;

		function new();
			nblk = 1;
			slen = 0;
			thr = 32'(blsm_pkg::THR_RESET);
			errors = 0;
			blk_lo[0] = 0;
			blk_hi[0] = 0;
		endfunction

		function void set_threshold(logic [6:0] v);
			thr = 32'(v);
		endfunction

		function int unsigned span(int unsigned lo, int unsigned hi);
			return (hi >= lo) ? hi - lo : 0;
		endfunction

		// copy the string into logical order, one block afterwards
		function void rebuild_if_needed();
			logic [7:0]  copy[STORE_LEN];
			int unsigned k;
			int unsigned lim;
			lim = (thr < BLOCKS) ? thr : BLOCKS;
			if (nblk <= lim)
				return;
			copy = chars;
			k = 0;
			for (int unsigned i = 0; i < nblk && i < TBL; i++)
				for (int unsigned j = blk_lo[i]; j < blk_hi[i]; j++)
					if (j < STORE_LEN && k < STORE_LEN) begin
						copy[k] = chars[j];
						k++;
					end
			chars = copy;
			nblk = 1;
			blk_lo[0] = 0;
			blk_hi[0] = slen;
		endfunction

		function void add_piece(ref int unsigned cnt, input int unsigned lo, int unsigned hi);
			if (cnt < TBL) begin
				piece_lo[cnt] = lo;
				piece_hi[cnt] = hi;
				cnt++;
			end
		endfunction

		function void cut_to_end(int unsigned a, int unsigned b);
			int unsigned pos, cnt, len, ca, cb;
			bit          ha, hb, mid;
			pos = 0;
			cnt = 0;
			for (int unsigned i = 0; i < nblk && i < TBL; i++) begin
				len = span(blk_lo[i], blk_hi[i]);
				ha = pos < a && pos + len > a;
				hb = pos < b && pos + len > b;
				ca = blk_lo[i] + (a - pos);
				cb = blk_lo[i] + (b - pos);
				if (ha && hb) begin
					add_piece(cnt, blk_lo[i], ca);
					add_piece(cnt, ca, cb);
					add_piece(cnt, cb, blk_hi[i]);
				end else if (ha) begin
					add_piece(cnt, blk_lo[i], ca);
					add_piece(cnt, ca, blk_hi[i]);
				end else if (hb) begin
					add_piece(cnt, blk_lo[i], cb);
					add_piece(cnt, cb, blk_hi[i]);
				end else begin
					add_piece(cnt, blk_lo[i], blk_hi[i]);
				end
				pos += len;
			end
			nblk = 0;
			// pieces outside [a,b) first, then the moved ones
			for (int p = 0; p < 2; p++) begin
				pos = 0;
				for (int unsigned i = 0; i < cnt; i++) begin
					mid = pos >= a && pos < b;
					if (mid == (p == 1) && nblk < TBL) begin
						blk_lo[nblk] = piece_lo[i];
						blk_hi[nblk] = piece_hi[i];
						nblk++;
					end
					pos += span(piece_lo[i], piece_hi[i]);
				end
			end
		endfunction

		function void note_word(logic [1:0] c, logic f, logic [7:0] ch,
				logic [12:0] a, logic [12:0] b);
			mover_result_t r;
			int unsigned   pos, len, idx;
			r.chr = 8'd0;
			r.st = 1'b0;
			if (c == blsm_pkg::CMD_APPEND) begin
				if (f) begin
					slen = 0;
					nblk = 1;
					blk_lo[0] = 0;
					blk_hi[0] = 0;
				end
				if (slen >= STORE_LEN) begin
					r.st = 1'b1;
				end else begin
					chars[slen] = ch;
					if (nblk > 0 && nblk <= TBL && blk_hi[nblk - 1] == slen) begin
						blk_hi[nblk - 1] = slen + 1;
					end else if (nblk < TBL) begin
						blk_lo[nblk] = slen;
						blk_hi[nblk] = slen + 1;
						nblk++;
					end
					slen++;
					rebuild_if_needed();
				end
			end else if (c == blsm_pkg::CMD_CUT) begin
				cut_to_end(32'(a), 32'(b));
				rebuild_if_needed();
			end else if (c == blsm_pkg::CMD_READ) begin
				if (a >= slen) begin
					r.st = 1'b1;
				end else begin
					pos = 0;
					for (int unsigned i = 0; i < nblk && i < TBL; i++) begin
						len = span(blk_lo[i], blk_hi[i]);
						if (a < pos + len) begin
							idx = blk_lo[i] + (a - pos);
							if (idx < STORE_LEN)
								r.chr = chars[idx];
							break;
						end
						pos += len;
					end
				end
			end
			r.blocks = nblk[7:0];
			pending.push_back(r);
		endfunction

		function void check_word(logic [7:0] ch, logic st, logic [7:0] bc);
			mover_result_t e;
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ch !== e.chr) begin
				$error("char_out expected %0d actual %0d", e.chr, ch);
				errors++;
			end
			if (st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, st);
				errors++;
			end
			if (bc !== e.blocks) begin
				$error("block_count expected %0d actual %0d", e.blocks, bc);
				errors++;
			end
		endfunction
	endclass

	blsm_scoreboard board;
	bit             calm;          // no idling on either side while set
	int unsigned    cycles;
	int unsigned    cur_len;       // string length as the stimulus tracks it

	block_list_substring_mover dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .first(first), .char_in(char_in), .pos_a(pos_a), .pos_b(pos_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_out(char_out), .status(status), .block_count(block_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run bound
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: sample at the rising edge, move ready at the falling edge
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = calm || ($urandom_range(99) >= 24);
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_word(char_out, status, block_count);
		end
	end

	function automatic logic [7:0] rnd_char();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [12:0] rnd_pos();
		return 13'($urandom_range(8191));
	endfunction

	// one input word, random gap ahead of it, held until accepted
	task automatic send_word(logic [1:0] c, logic f, logic [7:0] ch,
			logic [12:0] a, logic [12:0] b);
		@(negedge clk);
		in_valid = 1'b0;
		while (!calm && $urandom_range(99) < 24)
			@(negedge clk);
		in_valid = 1'b1;
		cmd = c;
		first = f;
		char_in = ch;
		pos_a = a;
		pos_b = b;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_word(c, f, ch, a, b);
		// keep a local view of the length for shaping positions
		if (c == blsm_pkg::CMD_APPEND) begin
			if (f)
				cur_len = 0;
			if (cur_len < STORE_LEN)
				cur_len++;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		// results all in; let the sequencer settle before touching the register
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [6:0] v);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_threshold(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [12:0] pick_pos();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return rnd_pos();
		if (r < 10)
			return cur_len[12:0];
		return 13'($urandom_range(cur_len));
	endfunction

	task automatic random_phase(int n);
		int unsigned r, grow;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				// restart the string and build it up
				send_word(blsm_pkg::CMD_APPEND, 1'b1, rnd_char(), rnd_pos(), rnd_pos());
				grow = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(40);
				for (int j = 0; j < grow; j++)
					send_word(blsm_pkg::CMD_APPEND, 1'b0, rnd_char(), rnd_pos(), rnd_pos());
				i += int'(grow);
			end else if (r < 20) begin
				send_word(blsm_pkg::CMD_APPEND, 1'b0, rnd_char(), rnd_pos(), rnd_pos());
			end else if (r < 55) begin
				send_word(blsm_pkg::CMD_CUT, rnd_bit(), rnd_char(), pick_pos(), pick_pos());
			end else if (r < 97) begin
				send_word(blsm_pkg::CMD_READ, rnd_bit(), rnd_char(), pick_pos(), rnd_pos());
			end else begin
				// unused command code
				send_word(CMD_UNUSED, rnd_bit(), rnd_char(), rnd_pos(), rnd_pos());
			end
		end
	endtask

	initial begin
		board = new();
		cycles = 0;
		cur_len = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 7'd0;
		in_valid = 1'b0;
		cmd = blsm_pkg::CMD_APPEND;
		first = 1'b0;
		char_in = 8'd0;
		pos_a = 13'd0;
		pos_b = 13'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: a read on the empty string, cut on nothing, unused command
		send_word(blsm_pkg::CMD_READ, 1'b0, 8'h00, 13'd0, 13'd0);
		send_word(blsm_pkg::CMD_CUT, 1'b0, 8'h00, 13'd0, 13'd8191);
		send_word(CMD_UNUSED, 1'b1, 8'hFF, 13'd8191, 13'd8191);
		send_word(blsm_pkg::CMD_APPEND, 1'b1, 8'hFF, 13'd0, 13'd0);
		for (int j = 0; j < 7; j++)
			send_word(blsm_pkg::CMD_APPEND, 1'b0, 8'(16 + j), 13'd0, 13'd0);
		send_word(blsm_pkg::CMD_CUT, 1'b0, 8'h00, 13'd2, 13'd5);     // split, move a middle range
		send_word(blsm_pkg::CMD_CUT, 1'b0, 8'h00, 13'd3, 13'd4);     // both ends in one block
		send_word(blsm_pkg::CMD_CUT, 1'b0, 8'h00, 13'd6, 13'd1);     // reversed range
		send_word(blsm_pkg::CMD_CUT, 1'b0, 8'h00, 13'd5, 13'd8191);  // end beyond the length
		send_word(blsm_pkg::CMD_APPEND, 1'b0, 8'h00, 13'd0, 13'd0);  // append after a cut
		for (int j = 0; j < 9; j++)
			send_word(blsm_pkg::CMD_READ, 1'b0, 8'h00, 13'(j), 13'd0);
		send_word(blsm_pkg::CMD_READ, 1'b0, 8'h00, 13'd8191, 13'd0);

		// store full: fill every slot, then one more is refused
		send_word(blsm_pkg::CMD_APPEND, 1'b1, rnd_char(), 13'd0, 13'd0);
		for (int j = 1; j < STORE_LEN; j++)
			send_word(blsm_pkg::CMD_APPEND, 1'b0, rnd_char(), 13'd0, 13'd0);
		send_word(blsm_pkg::CMD_APPEND, 1'b0, 8'hAA, 13'd0, 13'd0);
		send_word(blsm_pkg::CMD_READ, 1'b0, 8'h00, 13'd4095, 13'd0);
		send_word(blsm_pkg::CMD_READ, 1'b0, 8'h00, 13'd4096, 13'd0);
		send_word(blsm_pkg::CMD_CUT, 1'b0, 8'h00, 13'd100, 13'd4000);
		send_word(blsm_pkg::CMD_READ, 1'b0, 8'h00, 13'd0, 13'd0);
		send_word(blsm_pkg::CMD_APPEND, 1'b1, 8'h01, 13'd0, 13'd0);  // first on a full store

		// lowest threshold: every second block flattens
		write_threshold(7'd1);
		random_phase(200);

		// long calm stretch, no idling on either side
		write_threshold(7'd63);
		calm = 1'b1;
		random_phase(300);
		calm = 1'b0;

		write_threshold(7'd8);
		random_phase(300);

		// sender holds off until every expected result is in
		drain();
		write_threshold(7'd64);
		random_phase(300);

		write_threshold(7'd3);
		random_phase(200);

		write_threshold(7'd64);
		random_phase(200);

		drain();
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
